// ===== src/sm4_pkg.sv =====
// Package: SM4 constants, S-box and round functions shared by the block.
package sm4_pkg;

  localparam int Rounds = 32;
  localparam int RkAddrW = $clog2(Rounds);

  localparam logic [2:0] MODE_ECB_ENC = 3'd0;
  localparam logic [2:0] MODE_ECB_DEC = 3'd1;
  localparam logic [2:0] MODE_CBC_ENC = 3'd2;
  localparam logic [2:0] MODE_CBC_DEC = 3'd3;
  localparam logic [2:0] MODE_CTR128 = 3'd4;
  localparam logic [2:0] MODE_CTR32 = 3'd5;

  localparam logic [2:0] REG_KEY_HIGH = 3'd0;
  localparam logic [2:0] REG_KEY_LOW = 3'd1;
  localparam logic [2:0] REG_IV_HIGH = 3'd2;
  localparam logic [2:0] REG_IV_LOW = 3'd3;
  localparam logic [2:0] REG_MODE = 3'd4;

  localparam logic [31:0] FK0 = 32'ha3b1bac6;
  localparam logic [31:0] FK1 = 32'h56aa3350;
  localparam logic [31:0] FK2 = 32'h677d9197;
  localparam logic [31:0] FK3 = 32'hb27022dc;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] subst_word(input logic [31:0] v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] round_mix(input logic [31:0] v);
    logic [31:0] b;
    b = subst_word(v);
    return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  function automatic logic [31:0] key_mix(input logic [31:0] v);
    logic [31:0] b;
    b = subst_word(v);
    return b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  // CK byte j of round i is 7*(4i+j) mod 256
  function automatic logic [31:0] ck_word(input logic [RkAddrW-1:0] i);
    logic [7:0] base;
    base = {i, 2'b00} * 8'd7;
    return {base, base + 8'd7, base + 8'd14, base + 8'd21};
  endfunction

  typedef struct packed {
    logic       start;
    logic       expand;
    logic       decrypt;
    logic [127:0] block;
  } sm4_cmd_t;

endpackage

// ===== src/sm4_rk_mem.sv =====
// Round key memory: one write port, one registered read port.
module sm4_rk_mem #(
  parameter int ROUNDS = sm4_pkg::Rounds
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(ROUNDS)-1:0]  wr_addr,
  input  logic [31:0]                wr_data,
  input  logic [$clog2(ROUNDS)-1:0]  rd_addr,
  output logic [31:0]                rd_data
);
  logic [31:0] mem [ROUNDS];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== src/sm4_core.sv =====
// Round engine: key expansion and 32 cipher rounds against the key memory.
module sm4_core #(
  parameter int ROUNDS = sm4_pkg::Rounds
) (
  input  logic             clk,
  input  logic             rst,
  input  sm4_pkg::sm4_cmd_t cmd,
  input  logic [127:0]     key,
  output logic             done,
  output logic [127:0]     block_out
);
  localparam int AW = $clog2(ROUNDS);

  typedef enum logic [1:0] {S_IDLE, S_EXP, S_PRIME, S_RUN} state_t;
  state_t state;
  logic [AW-1:0] cnt;
  logic [31:0] k0, k1, k2, k3, x0, x1, x2, x3;
  logic [31:0] rk;
  logic [31:0] kn, xn;
  logic decrypt;
  logic [AW-1:0] rd_addr;
  logic wr_en;

  assign kn = k0 ^ sm4_pkg::key_mix(k1 ^ k2 ^ k3 ^ sm4_pkg::ck_word(cnt));
  assign xn = x0 ^ sm4_pkg::round_mix(x1 ^ x2 ^ x3 ^ rk);
  assign wr_en = (state == S_EXP);

  // read address runs one ahead of the round that uses it
  always_comb begin
    logic [AW-1:0] idx;
    idx = (state == S_RUN) ? cnt + AW'(1) : '0;
    rd_addr = decrypt ? AW'(ROUNDS - 1) - idx : idx;
  end

  sm4_rk_mem #(.ROUNDS(ROUNDS)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(cnt), .wr_data(kn),
    .rd_addr(rd_addr), .rd_data(rk)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.start) begin
            decrypt <= cmd.decrypt;
            {x0, x1, x2, x3} <= cmd.block;
            cnt <= '0;
            if (cmd.expand) begin
              k0 <= key[127:96] ^ sm4_pkg::FK0;
              k1 <= key[95:64] ^ sm4_pkg::FK1;
              k2 <= key[63:32] ^ sm4_pkg::FK2;
              k3 <= key[31:0] ^ sm4_pkg::FK3;
              state <= S_EXP;
            end else begin
              state <= S_PRIME;
            end
          end
        end
        S_EXP: begin
          {k0, k1, k2, k3} <= {k1, k2, k3, kn};
          cnt <= cnt + AW'(1);
          if (cnt == AW'(ROUNDS - 1)) state <= S_PRIME;
        end
        S_PRIME: begin
          cnt <= '0;
          state <= S_RUN;
        end
        S_RUN: begin
          {x0, x1, x2, x3} <= {x1, x2, x3, xn};
          cnt <= cnt + AW'(1);
          if (cnt == AW'(ROUNDS - 1)) begin
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign block_out = {x3, x2, x1, x0};
endmodule

// ===== src/sm4_block_cipher_modes_top.sv =====
// Top level: SM4 ECB/CBC/CTR engine with config port and valid/ready channels.
//
// Write key, iv and mode through cfg_we/cfg_index/cfg_data while idle.
// Each input transfer carries one 128-bit block; one result follows with
// the output block and the updated chaining value or counter.
// Each block runs a prime state, then 32 rounds one per cycle, then its
// result is registered into the output. After a key write or reset the first
// block also runs the key expansion into the round key memory.
// The round loop through the single-port-read key memory sets the rate:
// one block in flight; a new block is taken only once the last one is done.
// in_ready is high only when no block is in flight and the holding register
// is empty. A stalled receiver keeps the result; one more block may finish
// into the holding register, after which input stalls until it drains.
// Reset clears key, iv, mode, chaining value and key-valid flag; the round
// key memory is refilled on the next block.
// first_block reloads the chaining value from iv before the block runs.
module sm4_block_cipher_modes_top #(
  parameter int ROUNDS = sm4_pkg::Rounds
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] data_high,
  input  logic [63:0] data_low,
  input  logic        first_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_high,
  output logic [63:0] result_low,
  output logic [63:0] chain_high,
  output logic [63:0] chain_low
);
  logic [63:0] key_high, key_low, iv_high, iv_low;
  logic [2:0] cipher_mode;
  logic keys_ready;
  logic [127:0] chain;
  logic busy;
  logic [127:0] din;
  logic [2:0] mode_q;
  sm4_pkg::sm4_cmd_t cmd;
  logic done;
  logic [127:0] core_out;
  logic [127:0] chain_in, res_next, chain_next;
  logic accept;
  logic key_write;
  logic hold_valid;
  logic [127:0] hold_res, hold_chain;

  assign in_ready = !busy && !hold_valid;
  assign accept = in_valid && in_ready;
  assign chain_in = first_block ? {iv_high, iv_low} : chain;
  assign key_write = cfg_we && (cfg_index == sm4_pkg::REG_KEY_HIGH ||
                                cfg_index == sm4_pkg::REG_KEY_LOW);

  always_comb begin
    cmd.start = accept;
    cmd.expand = !keys_ready;
    cmd.decrypt = (cipher_mode == sm4_pkg::MODE_ECB_DEC) ||
                  (cipher_mode == sm4_pkg::MODE_CBC_DEC);
    case (cipher_mode) inside
      sm4_pkg::MODE_CBC_ENC: cmd.block = {data_high, data_low} ^ chain_in;
      sm4_pkg::MODE_CTR128, sm4_pkg::MODE_CTR32: cmd.block = chain_in;
      default: cmd.block = {data_high, data_low};
    endcase
  end

  sm4_core #(.ROUNDS(ROUNDS)) u_core (
    .clk(clk), .rst(rst), .cmd(cmd), .key({key_high, key_low}),
    .done(done), .block_out(core_out)
  );

  always_comb begin
    res_next = core_out;
    chain_next = chain;
    unique case (mode_q) inside
      sm4_pkg::MODE_ECB_ENC, sm4_pkg::MODE_ECB_DEC: ;
      sm4_pkg::MODE_CBC_ENC: chain_next = core_out;
      sm4_pkg::MODE_CBC_DEC: begin
        res_next = core_out ^ chain;
        chain_next = din;
      end
      sm4_pkg::MODE_CTR128: begin
        res_next = core_out ^ din;
        chain_next = chain + 128'd1;
      end
      sm4_pkg::MODE_CTR32: begin
        res_next = core_out ^ din;
        chain_next = {chain[127:32], chain[31:0] + 32'd1};
      end
      default: res_next = din;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0; key_low <= '0; iv_high <= '0; iv_low <= '0;
      cipher_mode <= '0;
      keys_ready <= 1'b0;
      chain <= '0;
      busy <= 1'b0;
      out_valid <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sm4_pkg::REG_KEY_HIGH: key_high <= cfg_data;
          sm4_pkg::REG_KEY_LOW: key_low <= cfg_data;
          sm4_pkg::REG_IV_HIGH: iv_high <= cfg_data;
          sm4_pkg::REG_IV_LOW: iv_low <= cfg_data;
          sm4_pkg::REG_MODE: cipher_mode <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (key_write) keys_ready <= 1'b0;
      else if (accept) keys_ready <= 1'b1;
      if (accept) begin
        busy <= 1'b1;
        chain <= chain_in;
        din <= {data_high, data_low};
        mode_q <= cipher_mode;
      end
      if (done) begin
        busy <= 1'b0;
        chain <= chain_next;
      end
      // drain holding reg first; park a finished block while receiver stalls
      if (!out_valid || out_ready) begin
        if (hold_valid) begin
          out_valid <= 1'b1;
          {result_high, result_low} <= hold_res;
          {chain_high, chain_low} <= hold_chain;
          hold_valid <= 1'b0;
        end else if (done) begin
          out_valid <= 1'b1;
          {result_high, result_low} <= res_next;
          {chain_high, chain_low} <= chain_next;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (done) begin
        hold_valid <= 1'b1;
        hold_res <= res_next;
        hold_chain <= chain_next;
      end
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready) else $error("input taken while busy");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("core finished with no block in flight");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_high))
    else $error("result dropped under stall");
endmodule
